// ===== sv/cddr_pkg.sv =====
`timescale 1ns / 1ps

package cddr_pkg;

    localparam int unsigned LEN_W  = 28;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned OP_W   = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] SAT_MAX = '1;

    // CIGAR operations that the detector acts on; all other codes are ignored.
    localparam logic [OP_W-1:0] OP_MATCH     = 4'd0;
    localparam logic [OP_W-1:0] OP_INSERTION = 4'd1;
    localparam logic [OP_W-1:0] OP_DELETION  = 4'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_START = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd3;

    localparam logic [WORD_W-1:0] RST_MIN_DEL   = 32'd50;
    localparam logic [WORD_W-1:0] RST_MAX_DEL   = 32'd100000;
    localparam logic [LEN_W-1:0]  RST_MIN_START = 28'd10;
    localparam logic [WORD_W-1:0] RST_LIMIT     = 32'd20;

    typedef struct packed {
        logic [WORD_W-1:0] min_deletion_length;
        logic [WORD_W-1:0] max_deletion_length;
        logic [LEN_W-1:0]  min_starting_length;
        logic [WORD_W-1:0] interference_limit;
    } t_cfg;

    typedef struct packed {
        logic [WORD_W-1:0] read_position;
        logic [OP_W-1:0]   op_code;
        logic [LEN_W-1:0]  op_length;
        logic              last_element;
    } t_elem;

    function automatic logic [WORD_W-1:0] sat33(input logic [WORD_W:0] s);
        return s[WORD_W] ? SAT_MAX : s[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] sat34(input logic [WORD_W+1:0] s);
        return (s[WORD_W+1:WORD_W] != 2'b00) ? SAT_MAX : s[WORD_W-1:0];
    endfunction

endpackage

// ===== sv/cddr_elem_if.sv =====
`timescale 1ns / 1ps

interface cddr_elem_if;
    logic                       valid;
    logic                       ready;
    logic [cddr_pkg::WORD_W-1:0] read_position;
    logic [cddr_pkg::OP_W-1:0]   op_code;
    logic [cddr_pkg::LEN_W-1:0]  op_length;
    logic                       last_element;

    modport source (
        output valid, read_position, op_code, op_length, last_element,
        input  ready
    );
    modport sink (
        input  valid, read_position, op_code, op_length, last_element,
        output ready
    );
endinterface

// ===== sv/cddr_result_if.sv =====
`timescale 1ns / 1ps

interface cddr_result_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [cddr_pkg::WORD_W-1:0] deletion_start;
    logic [cddr_pkg::WORD_W-1:0] deletion_length;

    modport source (
        output valid, found, deletion_start, deletion_length,
        input  ready
    );
    modport sink (
        input  valid, found, deletion_start, deletion_length,
        output ready
    );
endinterface

// ===== sv/cigar_deletion_run_detector.sv =====
`timescale 1ns / 1ps
// A result is loaded into the result register when the tracker takes its alignment's last word.
// The tracker takes one CIGAR word per cycle, but for the stall below; the run state is registered.
// A last word waits in the input register while the previous result is still untaken.
// Reset (synchronous, active low) clears the run state and both handshakes and loads
// the register defaults: bounds 50 to 100000, opening length 10, interference 20.

module cigar_deletion_run_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cddr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cddr_pkg::WORD_W-1:0]    i_cfg_data,
    cddr_elem_if.sink                     i_elem,
    cddr_result_if.source                 o_res
);
    import cddr_pkg::*;

    t_cfg  cfg;
    t_elem stage_elem;
    logic  stage_valid;
    logic  stage_take;

    cddr_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    cddr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_elem  (i_elem),
        .i_take  (stage_take),
        .o_valid (stage_valid),
        .o_elem  (stage_elem)
    );

    cddr_run_tracker u_run_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (stage_valid),
        .i_elem  (stage_elem),
        .o_take  (stage_take),
        .o_res   (o_res)
    );

endmodule

// ===== sv/cddr_cfg_regs.sv =====
`timescale 1ns / 1ps

module cddr_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cddr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cddr_pkg::WORD_W-1:0]    i_cfg_data,
    output cddr_pkg::t_cfg                o_cfg
);
    import cddr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_deletion_length <= RST_MIN_DEL;
            r_cfg.max_deletion_length <= RST_MAX_DEL;
            r_cfg.min_starting_length <= RST_MIN_START;
            r_cfg.interference_limit  <= RST_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_DEL:   r_cfg.min_deletion_length <= i_cfg_data;
                CFG_MAX_DEL:   r_cfg.max_deletion_length <= i_cfg_data;
                CFG_MIN_START: r_cfg.min_starting_length <= i_cfg_data[LEN_W-1:0];
                CFG_LIMIT:     r_cfg.interference_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/cddr_in_stage.sv =====
`timescale 1ns / 1ps

module cddr_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cddr_elem_if.sink      i_elem,
    input  logic           i_take,
    output logic           o_valid,
    output cddr_pkg::t_elem o_elem
);
    import cddr_pkg::*;

    logic  r_valid;
    t_elem r_elem;
    logic  accept;

    // The register refills in the same cycle as the tracker takes its word.
    assign i_elem.ready = !r_valid || i_take;
    assign accept       = i_elem.valid && i_elem.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_elem.read_position <= i_elem.read_position;
            r_elem.op_code       <= i_elem.op_code;
            r_elem.op_length     <= i_elem.op_length;
            r_elem.last_element  <= i_elem.last_element;
        end
    end

    assign o_valid = r_valid;
    assign o_elem  = r_elem;

endmodule

// ===== sv/cddr_run_tracker.sv =====
`timescale 1ns / 1ps

module cddr_run_tracker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cddr_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  cddr_pkg::t_elem i_elem,
    output logic            o_take,
    cddr_result_if.source   o_res
);
    import cddr_pkg::*;

    logic              r_in_run,  n_in_run;
    logic              r_decided, n_decided;
    logic [WORD_W-1:0] r_ref_off, n_ref_off;
    logic [WORD_W-1:0] r_icount,  n_icount;
    logic [WORD_W-1:0] r_match,   n_match;
    logic [WORD_W-1:0] r_total,   n_total;
    logic [WORD_W-1:0] r_start,   n_start;

    logic              r_res_valid;
    logic              r_found;
    logic [WORD_W-1:0] r_del_start;
    logic [WORD_W-1:0] r_del_len;

    logic              adv;
    logic              done;
    logic [WORD_W-1:0] len_ext;
    logic [WORD_W-1:0] icount_add;
    logic [WORD_W-1:0] match_add;
    logic              over_limit;
    logic              total_ok;
    logic              final_ok;
    logic              res_found;

    // A last word may only move on once the result register has room.
    assign adv    = i_valid && (!i_elem.last_element || !r_res_valid || o_res.ready);
    assign o_take = adv;
    assign done   = adv && i_elem.last_element;

    assign len_ext    = {{(WORD_W-LEN_W){1'b0}}, i_elem.op_length};
    assign icount_add = sat33({1'b0, r_icount} + {1'b0, len_ext});
    assign match_add  = sat33({1'b0, r_match} + {1'b0, len_ext});
    assign over_limit = icount_add > i_cfg.interference_limit;
    assign total_ok   = (r_total >= i_cfg.min_deletion_length)
                     && (r_total <= i_cfg.max_deletion_length);

    always_comb begin
        n_in_run  = r_in_run;
        n_decided = r_decided;
        n_ref_off = r_ref_off;
        n_icount  = r_icount;
        n_match   = r_match;
        n_total   = r_total;
        n_start   = r_start;
        if (!r_decided) begin
            case (i_elem.op_code)
                OP_DELETION: begin
                    n_ref_off = r_ref_off + len_ext;
                    if (r_in_run || (i_elem.op_length >= i_cfg.min_starting_length)) begin
                        if (!r_in_run) begin
                            n_start  = i_elem.read_position + r_ref_off;
                            n_in_run = 1'b1;
                        end
                        // Absorbed match bases and this deletion join the total at once.
                        n_total  = sat34({2'b00, r_total} + {2'b00, r_match}
                                       + {2'b00, len_ext});
                        n_match  = '0;
                        n_icount = '0;
                    end
                end
                OP_MATCH: begin
                    n_ref_off = r_ref_off + len_ext;
                    if (r_in_run) begin
                        n_icount = icount_add;
                        n_match  = match_add;
                        if (over_limit) begin
                            if (total_ok) begin
                                n_decided = 1'b1;
                            end else begin
                                n_icount = '0;
                                n_match  = '0;
                                n_total  = '0;
                                n_in_run = 1'b0;
                            end
                        end
                    end
                end
                OP_INSERTION: begin
                    if (r_in_run) begin
                        n_icount = icount_add;
                        if (over_limit) begin
                            if (total_ok) begin
                                n_decided = 1'b1;
                            end else begin
                                n_icount = '0;
                                n_match  = '0;
                                n_total  = '0;
                                n_in_run = 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign final_ok  = (n_total >= i_cfg.min_deletion_length)
                    && (n_total <= i_cfg.max_deletion_length);
    assign res_found = n_decided || final_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || done) begin
            r_in_run  <= 1'b0;
            r_decided <= 1'b0;
            r_ref_off <= '0;
            r_icount  <= '0;
            r_match   <= '0;
            r_total   <= '0;
            r_start   <= '0;
        end else if (adv) begin
            r_in_run  <= n_in_run;
            r_decided <= n_decided;
            r_ref_off <= n_ref_off;
            r_icount  <= n_icount;
            r_match   <= n_match;
            r_total   <= n_total;
            r_start   <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (done) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_found     <= res_found;
            r_del_start <= res_found ? n_start : '0;
            r_del_len   <= res_found ? n_total : '0;
        end
    end

    assign o_res.valid           = r_res_valid;
    assign o_res.found           = r_found;
    assign o_res.deletion_start  = r_del_start;
    assign o_res.deletion_length = r_del_len;

    a_done_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> r_res_valid)
        else $error("result register not loaded after the last word");

    a_done_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (!r_in_run && !r_decided && r_ref_off == '0 && r_total == '0))
        else $error("alignment state not cleared after the last word");

    a_decided_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_decided |-> r_in_run)
        else $error("early acceptance without an open run");

    a_idle_no_interference: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_run |-> (r_icount == '0 && r_match == '0))
        else $error("interference held outside a run");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !o_res.ready) |-> !done)
        else $error("pending result overwritten");

endmodule

// ===== verif/cigar_deletion_run_detector_tb.sv =====
`timescale 1ns / 1ps

module cigar_deletion_run_detector_tb;
    import cddr_pkg::*;

    localparam int unsigned QUIET_LIMIT  = 1000;
    localparam int unsigned PHASE_WORDS  = 250;
    localparam int unsigned NUM_PHASES   = 6;
    localparam int unsigned REPORT_LIMIT = 10;

    // Op codes that the detector must pass over untouched.
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd3;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic              found;
        logic [WORD_W-1:0] start;
        logic [WORD_W-1:0] length;
    } t_run_report;

    typedef struct packed {
        logic [WORD_W-1:0] pos;
        logic [OP_W-1:0]   op;
        logic [LEN_W-1:0]  len;
        logic              last;
        logic              typed;
        t_run_report       want;
    } t_stim_row;

    localparam t_run_report NOT_FOUND = '{1'b0, 32'd0, 32'd0};

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [WORD_W-1:0] i_cfg_data;

    cddr_elem_if   elem_ch ();
    cddr_result_if res_ch ();

    cigar_deletion_run_detector dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_elem     (elem_ch),
        .o_res      (res_ch)
    );

    // Directed words under the reset register values. Typed rows carry their result.
    t_stim_row directed_rows [23] = '{
        '{32'hFFFF_FFFF, OP_UNUSED_HI, 28'hFFF_FFFF, 1'b1, 1'b1, NOT_FOUND},
        '{32'd0,         OP_DELETION,  28'd60,       1'b1, 1'b1, '{1'b1, 32'd0, 32'd60}},
        '{32'd1000,      OP_MATCH,     28'd5,        1'b0, 1'b0, NOT_FOUND},
        '{32'd1000,      OP_DELETION,  28'd5,        1'b0, 1'b0, NOT_FOUND},
        '{32'd1000,      OP_DELETION,  28'd30,       1'b0, 1'b0, NOT_FOUND},
        '{32'd1000,      OP_MATCH,     28'd15,       1'b0, 1'b0, NOT_FOUND},
        '{32'd1000,      OP_INSERTION, 28'd3,        1'b0, 1'b0, NOT_FOUND},
        '{32'd1000,      OP_DELETION,  28'd10,       1'b0, 1'b0, NOT_FOUND},
        '{32'd1000,      OP_MATCH,     28'd21,       1'b0, 1'b0, NOT_FOUND},
        '{32'd1000,      OP_DELETION,  28'd100,      1'b0, 1'b0, NOT_FOUND},
        '{32'd1000,      OP_UNUSED_LO, 28'd0,        1'b1, 1'b0, NOT_FOUND},
        '{32'd7,         OP_INSERTION, 28'd100,      1'b0, 1'b0, NOT_FOUND},
        '{32'd7,         OP_DELETION,  28'd10,       1'b0, 1'b0, NOT_FOUND},
        '{32'd7,         OP_UNUSED_LO, 28'd0,        1'b1, 1'b0, NOT_FOUND},
        '{32'hFFFF_FFF0, OP_MATCH,     28'd32,       1'b0, 1'b0, NOT_FOUND},
        '{32'hFFFF_FFF0, OP_DELETION,  28'd60,       1'b0, 1'b0, NOT_FOUND},
        '{32'hFFFF_FFF0, OP_MATCH,     28'd21,       1'b1, 1'b0, NOT_FOUND},
        '{32'd500,       OP_DELETION,  28'd10,       1'b0, 1'b0, NOT_FOUND},
        '{32'd500,       OP_MATCH,     28'd21,       1'b0, 1'b0, NOT_FOUND},
        '{32'd500,       OP_INSERTION, 28'd25,       1'b0, 1'b0, NOT_FOUND},
        '{32'd500,       OP_DELETION,  28'd9,        1'b0, 1'b0, NOT_FOUND},
        '{32'd500,       OP_DELETION,  28'd50,       1'b1, 1'b0, NOT_FOUND},
        '{32'd0,         OP_DELETION,  28'hFFF_FFFF, 1'b1, 1'b1, NOT_FOUND}
    };

    t_run_report expected_reports [$];
    int unsigned error_count;
    int unsigned quiet_cycles;
    bit          sender_gaps_on;
    bit          sink_stalls_on;

    // Run-tracking model of the detector.
    t_cfg              model_cfg;
    logic              run_open;
    logic              run_decided;
    logic [WORD_W-1:0] ref_offset;
    logic [WORD_W-1:0] interf_count;
    logic [WORD_W-1:0] absorbed_match;
    logic [WORD_W-1:0] run_total;
    logic [WORD_W-1:0] run_begin;

    function automatic logic [WORD_W-1:0] add_sat(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? '1 : s[WORD_W-1:0];
    endfunction

    function automatic bit total_in_bounds(input logic [WORD_W-1:0] t);
        return t >= model_cfg.min_deletion_length && t <= model_cfg.max_deletion_length;
    endfunction

    function automatic void clear_alignment_state();
        run_open       = 1'b0;
        run_decided    = 1'b0;
        ref_offset     = '0;
        interf_count   = '0;
        absorbed_match = '0;
        run_total      = '0;
        run_begin      = '0;
    endfunction

    function automatic void weigh_interference();
        if (interf_count > model_cfg.interference_limit) begin
            if (total_in_bounds(run_total)) begin
                run_decided = 1'b1;
            end else begin
                interf_count   = '0;
                absorbed_match = '0;
                run_total      = '0;
                run_open       = 1'b0;
            end
        end
    endfunction

    // Advances the model by one word; returns 1 when the word closes an alignment.
    function automatic bit predict_element(input t_elem e, output t_run_report rep);
        logic [WORD_W-1:0] len32;
        len32 = {{(WORD_W-LEN_W){1'b0}}, e.op_length};
        rep = NOT_FOUND;
        if (!run_decided) begin
            case (e.op_code)
                OP_DELETION: begin
                    if (!run_open && e.op_length < model_cfg.min_starting_length) begin
                        ref_offset = ref_offset + len32;
                    end else begin
                        if (!run_open) begin
                            run_begin = e.read_position + ref_offset;
                            run_open  = 1'b1;
                        end
                        run_total      = add_sat(add_sat(run_total, absorbed_match), len32);
                        absorbed_match = '0;
                        interf_count   = '0;
                        ref_offset     = ref_offset + len32;
                    end
                end
                OP_MATCH: begin
                    ref_offset = ref_offset + len32;
                    if (run_open) begin
                        interf_count   = add_sat(interf_count, len32);
                        absorbed_match = add_sat(absorbed_match, len32);
                        weigh_interference();
                    end
                end
                OP_INSERTION: begin
                    if (run_open) begin
                        interf_count = add_sat(interf_count, len32);
                        weigh_interference();
                    end
                end
                default: begin
                end
            endcase
        end
        if (!e.last_element)
            return 1'b0;
        if (run_decided || total_in_bounds(run_total))
            rep = '{1'b1, run_begin, run_total};
        clear_alignment_state();
        return 1'b1;
    endfunction

    function automatic void note_mismatch(input string what, input t_run_report want,
                                          input t_run_report got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display({"MISMATCH %s: expected found=%0d start=%h length=%h, ",
                      "got found=%0d start=%h length=%h"},
                     what, want.found, want.start, want.length,
                     got.found, got.start, got.length);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: checks every accepted result and stalls in short bursts.
    initial begin
        int unsigned stall_left;
        t_run_report got;
        t_run_report want;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                got = '{res_ch.found, res_ch.deletion_start, res_ch.deletion_length};
                if (expected_reports.size() == 0) begin
                    note_mismatch("unexpected result", NOT_FOUND, got);
                end else begin
                    want = expected_reports.pop_front();
                    if (got.found !== want.found)
                        note_mismatch("found", want, got);
                    else if (got.start !== want.start)
                        note_mismatch("deletion_start", want, got);
                    else if (got.length !== want.length)
                        note_mismatch("deletion_length", want, got);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 3);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((elem_ch.valid && elem_ch.ready) || (res_ch.valid && res_ch.ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("cigar_deletion_run_detector_tb: done, errors");
                $finish;
            end
        end
    end

    // Valid is only lowered for a gap, so a back-to-back word keeps it high.
    task automatic send_element(input t_elem e, input bit typed, input t_run_report want);
        t_run_report rep;
        if (sender_gaps_on && $urandom_range(0, 4) == 0) begin
            elem_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        elem_ch.valid         <= 1'b1;
        elem_ch.read_position <= e.read_position;
        elem_ch.op_code       <= e.op_code;
        elem_ch.op_length     <= e.op_length;
        elem_ch.last_element  <= e.last_element;
        do @(posedge i_clk); while (!elem_ch.ready);
        if (predict_element(e, rep))
            expected_reports.insert(expected_reports.size(), typed ? want : rep);
    endtask

    // Holds the sender back until every pending result is in and the pipeline is empty.
    task automatic wait_until_idle();
        elem_ch.valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_config(input t_cfg c);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MIN_DEL;
        i_cfg_data <= c.min_deletion_length;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MAX_DEL;
        i_cfg_data <= c.max_deletion_length;
        @(posedge i_clk);
        // The upper bits are junk; only the low 28 bits should be kept.
        i_cfg_idx  <= CFG_MIN_START;
        i_cfg_data <= {4'($urandom), c.min_starting_length};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LIMIT;
        i_cfg_data <= c.interference_limit;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        model_cfg = c;
    endtask

    function automatic logic [OP_W-1:0] pick_op(input bit noisy);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (noisy)
            return OP_W'($urandom);
        if (r < 7)
            return OP_DELETION;
        if (r < 13)
            return OP_MATCH;
        if (r < 17)
            return OP_INSERTION;
        return OP_W'($urandom_range(3, 15));
    endfunction

    function automatic logic [LEN_W-1:0] pick_length(input bit big, input int unsigned scale);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r == 2)
            return LEN_W'($urandom);
        if (big && r < 14)
            return '1;
        return LEN_W'($urandom_range(0, scale));
    endfunction

    task automatic send_alignment(input bit big, input int unsigned scale,
                                  inout int unsigned words);
        int unsigned n;
        bit noisy;
        logic [WORD_W-1:0] pos;
        t_elem e;
        n     = big ? $urandom_range(1, 40) : $urandom_range(1, 12);
        noisy = ($urandom_range(0, 9) == 0);
        pos   = $urandom;
        for (int unsigned k = 0; k < n; k++) begin
            e.read_position = ($urandom_range(0, 9) == 0) ? WORD_W'($urandom) : pos;
            e.op_code       = pick_op(noisy);
            e.op_length     = noisy ? LEN_W'($urandom) : pick_length(big, scale);
            e.last_element  = (k == n - 1);
            send_element(e, 1'b0, NOT_FOUND);
            words++;
        end
    endtask

    initial begin
        t_cfg        phase_cfg [NUM_PHASES];
        int unsigned phase_scale [NUM_PHASES];
        bit          phase_big [NUM_PHASES];
        int unsigned words;
        t_elem       e;
        logic [WORD_W-1:0] lo;

        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_idx             <= CFG_MIN_DEL;
        i_cfg_data            <= '0;
        elem_ch.valid         <= 1'b0;
        elem_ch.read_position <= '0;
        elem_ch.op_code       <= OP_MATCH;
        elem_ch.op_length     <= '0;
        elem_ch.last_element  <= 1'b0;
        error_count    = 0;
        sender_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        model_cfg = '{RST_MIN_DEL, RST_MAX_DEL, RST_MIN_START, RST_LIMIT};
        clear_alignment_state();

        // Saturating lengths and counts, all-zero bounds, min above max, random, reset values.
        phase_cfg[0] = '{32'd1, 32'hFFFF_FFFF, 28'hFFF_FFFF, 32'hFFFF_FFFF};
        phase_cfg[1] = '{32'd0, 32'd0, 28'd0, 32'd0};
        phase_cfg[2] = '{32'd200, 32'd100, 28'd5, 32'd10};
        for (int p = 3; p < 5; p++) begin
            lo = $urandom_range(10, 60);
            phase_cfg[p] = '{lo, lo + $urandom_range(0, 400), LEN_W'($urandom_range(1, 20)),
                             WORD_W'($urandom_range(0, 40))};
        end
        phase_cfg[5] = '{RST_MIN_DEL, RST_MAX_DEL, RST_MIN_START, RST_LIMIT};
        phase_scale = '{60, 3, 60, 60, 60, 40};
        phase_big   = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            e = '{directed_rows[r].pos, directed_rows[r].op, directed_rows[r].len,
                  directed_rows[r].last};
            send_element(e, directed_rows[r].typed, directed_rows[r].want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_until_idle();
            load_config(phase_cfg[p]);
            sink_stalls_on = (p != NUM_PHASES - 1);
            words = 0;
            while (words < PHASE_WORDS) begin
                sender_gaps_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 2) != 0);
                send_alignment(phase_big[p], phase_scale[p], words);
                if ($urandom_range(0, 49) == 0)
                    wait_until_idle();
            end
        end

        wait_until_idle();
        repeat (10) @(posedge i_clk);
        if (expected_reports.size() != 0)
            note_mismatch("result never arrived", expected_reports[0], NOT_FOUND);
        if (error_count == 0) begin
            $display("cigar_deletion_run_detector_tb: done, clean");
        end else begin
            $display("cigar_deletion_run_detector_tb: done, errors");
        end
        $finish;
    end

endmodule
